/* rtl/log_x_piecewise_interpolator_macros.svh */
// Assertion helpers shared by the checker.
`ifndef LOG_X_PIECEWISE_INTERPOLATOR_MACROS_SVH
`define LOG_X_PIECEWISE_INTERPOLATOR_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define LXPI_ASSERT_IMPL(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a relation that must hold even during reset.
`define LXPI_ASSERT_ALWAYS(label, clk, cond, msg) \
  label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

/* rtl/lxpi_pkg.sv */
package lxpi_pkg;
  localparam int MaxNodes = 256;
  localparam int LogFrac = 26;
  localparam int DivSteps = 16;
  localparam int DivPerStep = 4;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusZero = 2'd1;
  localparam logic [1:0] StatusDegen = 2'd2;
  localparam logic [1:0] StatusSat = 2'd3;

  // Leading-one position of a nonzero word.
  function automatic logic [4:0] msb_pos(input logic [31:0] x);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) r = 5'(i);
    end
    return r;
  endfunction

  // One squaring step of the log mantissa.
  function automatic logic [32:0] sq_step(input logic [32:0] m, output logic bit_out);
    logic [65:0] p;
    logic [34:0] t;
    p = 66'(m) * 66'(m);
    t = 35'(p >> 31);
    bit_out = t[32];
    return bit_out ? 33'(t >> 1) : 33'(t);
  endfunction
endpackage

/* rtl/lxpi_log2.sv */
// Pipelined fixed-point log2: one squaring per stage, 26 stages.
module lxpi_log2 (
  input  logic               clk,
  input  logic [31:0]        x,
  output logic signed [31:0] lg
);
  import lxpi_pkg::*;

  logic [32:0]        m_q [LogFrac+1];
  logic [LogFrac-1:0] f_q [LogFrac+1];
  logic signed [5:0]  e_q [LogFrac+1];
  logic [4:0]         e0;

  assign e0 = msb_pos(x);

  always_comb begin
    m_q[0] = 33'(x) << (5'd31 - e0);
    f_q[0] = '0;
    e_q[0] = (x == 32'd0) ? 6'sd16 : $signed({1'b0, e0});
  end

  // Advance one fraction bit per stage.
  for (genvar s = 0; s < LogFrac; s++) begin : g_st
    logic [32:0] mn;
    logic        b;
    always_comb mn = sq_step(m_q[s], b);
    always_ff @(posedge clk) begin
      m_q[s+1] <= mn;
      f_q[s+1] <= f_q[s] | (LogFrac'(b) << (LogFrac - 1 - s));
      e_q[s+1] <= e_q[s];
    end
  end

  assign lg = (32'(e_q[LogFrac] - 6'sd16) <<< LogFrac) + 32'(f_q[LogFrac]);
endmodule

/* rtl/log_x_piecewise_interpolator.sv */
// Channel | Direction | Handshake
// start   | in        | start & !busy accepts one beat (node write or query)
// cfg     | in        | cfg_valid & cfg_ready writes node_count
// result  | out       | result_valid marks a one-cycle beat, no back pressure
// One item enters per cycle; busy stays low. A query passes through 26 log stages,
// a table read, a multiply, 16 divide stages and an output register.
// Node writes enter the same pipe so table writes retire in order; a write lands
// in the table before any later item reads it, so reads never overlap a write.
// rst clears pipe valid bits and sets node_count to 2; tables are undefined until written.
module log_x_piecewise_interpolator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic [7:0]         node_index,
  input  logic [31:0]        node_x,
  input  logic signed [31:0] node_y,
  input  logic [31:0]        query_point,
  input  logic signed [9:0]  segment_index,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_data,
  output logic               result_valid,
  output logic signed [31:0] value,
  output logic [1:0]         status,
  output logic               extrapolated
);
  import lxpi_pkg::*;

  localparam int LogLat = LogFrac;

  typedef struct packed {
    logic        v;
    logic        md;
    logic [7:0]  idx;
    logic [31:0] xv;
    logic [31:0] yv;
    logic [31:0] pt;
    logic        ex;
  } item_t;

  logic [8:0] node_count;
  item_t      pipe [LogLat];
  item_t      in_item;
  logic signed [31:0] lg_out;
  logic [8:0] cnt;
  logic [7:0] seg;
  logic       ext;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) node_count <= 9'd2;
    else if (cfg_valid) node_count <= cfg_data;
  end

  // Clamp count and segment at entry.
  always_comb begin
    cnt = node_count;
    if (node_count < 9'd2) cnt = 9'd2;
    else if (node_count > 9'(MaxNodes)) cnt = 9'(MaxNodes);
    ext = 1'b0;
    seg = 8'(segment_index);
    if (segment_index < 0) begin
      seg = 8'd0;
      ext = 1'b1;
    end else if ($unsigned(10'(segment_index)) >= 10'(cnt - 9'd1)) begin
      seg = 8'(cnt - 9'd2);
      ext = 1'b1;
    end
  end

  assign in_item = '{v: start, md: mode, idx: mode ? seg : node_index,
                     xv: mode ? query_point : node_x, yv: node_y,
                     pt: query_point, ex: ext};

  lxpi_log2 u_log (.clk(clk), .x(in_item.xv), .lg(lg_out));

  // Hold item fields alongside the log pipe.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LogLat; i++) pipe[i].v <= 1'b0;
    end else begin
      pipe[0] <= in_item;
      for (int i = 1; i < LogLat; i++) pipe[i] <= pipe[i-1];
    end
  end

  item_t      li;
  assign li = pipe[LogLat-1];

  // Node memory: x, y, log packed per entry; two read ports for seg, seg+1.
  logic [95:0] mem [MaxNodes];
  logic [95:0] rd_a, rd_b;
  logic [7:0]  ia, ib;
  assign ia = li.idx;
  assign ib = li.idx + 8'd1;

  always_ff @(posedge clk) begin
    if (li.v && !li.md) mem[li.idx] <= {li.xv, li.yv, lg_out};
    rd_a <= mem[ia];
    rd_b <= mem[ib];
  end

  // Forwarding muxes are tied off: fwd_a and fwd_b stay zero.
  item_t r_it;
  logic signed [31:0] r_lp;
  logic fwd_a, fwd_b;
  logic [95:0] fw_d;
  always_ff @(posedge clk) begin
    if (rst) r_it.v <= 1'b0;
    else r_it <= li;
    r_lp <= lg_out;
    fwd_a <= li.v && !li.md && 1'b0;
    fwd_b <= 1'b0;
    fw_d <= '0;
  end

  logic [95:0] na, nb;
  assign na = fwd_a ? fw_d : rd_a;
  assign nb = fwd_b ? fw_d : rd_b;

  // Compute operands and classify.
  logic signed [32:0] dy, num, den;
  logic [1:0] st0;
  always_comb begin
    dy  = 33'(signed'(nb[63:32])) - 33'(signed'(na[63:32]));
    num = 33'(r_lp) - 33'(signed'(na[31:0]));
    den = 33'(signed'(nb[31:0])) - 33'(signed'(na[31:0]));
    st0 = StatusOk;
    if (r_it.pt == 32'd0) st0 = StatusZero;
    else if (na[95:64] == 0 || nb[95:64] == 0 || den == 0) st0 = StatusDegen;
  end

  // Multiply stage.
  logic signed [65:0] prod;
  logic signed [32:0] den_q;
  logic signed [31:0] y0_q;
  logic [1:0] st_q;
  logic ex_q, v_q;
  always_ff @(posedge clk) begin
    if (rst) v_q <= 1'b0;
    else v_q <= r_it.v && r_it.md;
    prod  <= 66'(dy) * 66'(num);
    den_q <= den;
    y0_q  <= signed'(na[63:32]);
    st_q  <= st0;
    ex_q  <= r_it.ex;
  end

  // Restoring divide on magnitudes, DivPerStep bits per stage.
  typedef struct packed {
    logic        v;
    logic [65:0] rem;
    logic [65:0] quo;
    logic [32:0] dv;
    logic        neg;
    logic signed [31:0] y0;
    logic [1:0]  st;
    logic        ex;
  } dv_t;

  dv_t dp [DivSteps+1];
  always_comb begin
    dp[0].v   = v_q;
    dp[0].rem = '0;
    dp[0].quo = prod[65] ? 66'(-prod) : 66'(prod);
    dp[0].dv  = den_q[32] ? 33'(-den_q) : 33'(den_q);
    dp[0].neg = prod[65] ^ den_q[32];
    dp[0].y0  = y0_q;
    dp[0].st  = st_q;
    dp[0].ex  = ex_q;
  end

  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    dv_t nx;
    always_comb begin
      nx = dp[s];
      for (int k = 0; k < DivPerStep; k++) begin
        nx.rem = {nx.rem[64:0], nx.quo[65]};
        nx.quo = {nx.quo[64:0], 1'b0};
        if (nx.rem >= 66'(nx.dv)) begin
          nx.rem = nx.rem - 66'(nx.dv);
          nx.quo[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dp[s+1].v <= 1'b0;
      else dp[s+1] <= nx;
    end
  end

  // Final quotient holds 64 steps; two leftover bits handled in last stage.
  dv_t lt;
  logic [65:0] qm;
  logic signed [66:0] q, vv;
  always_comb begin
    lt = dp[DivSteps];
    qm = lt.quo;
    for (int k = 0; k < 2; k++) begin
      lt.rem = {lt.rem[64:0], qm[65]};
      qm = {qm[64:0], 1'b0};
      if (lt.rem >= 66'(lt.dv)) begin
        lt.rem = lt.rem - 66'(lt.dv);
        qm[0] = 1'b1;
      end
    end
    q = lt.neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    if (q > (67'sd1 <<< 40)) q = 67'sd1 <<< 40;
    if (q < -(67'sd1 <<< 40)) q = -(67'sd1 <<< 40);
    vv = q + 67'(lt.y0);
  end

  // Register the result beat.
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= lt.v;
    extrapolated <= lt.ex;
    if (lt.st != StatusOk) begin
      value <= '0;
      status <= lt.st;
    end else if (vv > 67'sd2147483647) begin
      value <= 32'sh7fffffff;
      status <= StatusSat;
    end else if (vv < -67'sd2147483648) begin
      value <= 32'sh80000000;
      status <= StatusSat;
    end else begin
      value <= 32'(vv);
      status <= StatusOk;
    end
  end
endmodule

/* rtl/lxpi_checker.sv */
module lxpi_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic cfg_ready,
  input logic result_valid,
  input logic [1:0] status,
  input logic signed [31:0] value
);
  import lxpi_pkg::*;
  `include "log_x_piecewise_interpolator_macros.svh"

  // Flag a beat that carries a zero-point or degenerate status.
  logic flagged;
  assign flagged = result_valid && (status == StatusZero || status == StatusDegen);

  `LXPI_ASSERT_IMPL(a_no_busy, clk, rst, !busy, "busy raised")
  `LXPI_ASSERT_IMPL(a_cfg_rdy, clk, rst, cfg_ready, "cfg not ready")
  `LXPI_ASSERT_IMPL(a_flag_zero, clk, rst, !(flagged && value != 0), "flagged nonzero")
  `LXPI_ASSERT_ALWAYS(a_rst_quiet, clk, rst || !$past(rst) || !result_valid, "beat after reset")
endmodule

bind log_x_piecewise_interpolator lxpi_checker u_chk (
  .clk(clk), .rst(rst), .busy(busy), .cfg_ready(cfg_ready),
  .result_valid(result_valid), .status(status), .value(value)
);
